>>> hw/rtl/bgc_pkg.sv
// Shared types, constants and register codes for the battery gauge conditioner.
package bgc_pkg;

   localparam int WIN_LEN = 5;
   localparam int PCT_W   = 7;
   localparam int CNT_W   = $clog2(WIN_LEN + 1);
   localparam int MV_W    = 14;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 7;

   // status byte decode
   localparam int         SUPPLY_BIT = 5;
   localparam logic [7:0] GAUGE_MAX  = 8'd100;
   localparam logic [2:0] DIR_CHARGE = 3'd1;
   localparam logic [2:0] CHG_CV     = 3'd3;
   localparam logic [2:0] CHG_DONE   = 3'd4;
   localparam logic [3:0] PHASE_NONE = 4'hF;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_LOW_THRESHOLD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOW_MARGIN    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPORT_STEP   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SETTLE_COUNT  = 2'd3;

   localparam logic [PCT_W-1:0] RST_LOW_THRESHOLD = 7'd20;
   localparam logic [PCT_W-1:0] RST_LOW_MARGIN    = 7'd5;
   localparam logic [PCT_W-1:0] RST_REPORT_STEP   = 7'd2;
   localparam logic [2:0]       RST_SETTLE_COUNT  = 3'd3;

   typedef logic [WIN_LEN-1:0][PCT_W-1:0] win_type;

   typedef struct packed {
      logic [PCT_W-1:0] low_threshold;
      logic [PCT_W-1:0] release_margin;
      logic [PCT_W-1:0] report_step;
      logic [2:0]       settle_count;
   } cfg_type;

   typedef struct packed {
      logic       read_ok;
      logic [7:0] status_one;
      logic [7:0] status_two;
      logic [7:0] volt_high;
      logic [7:0] volt_low;
      logic [7:0] gauge_byte;
   } item_type;

   typedef struct packed {
      logic            status_valid;
      logic [PCT_W-1:0] percent_out;
      logic [MV_W-1:0] millivolts;
      logic            is_charging;
      logic            is_full;
      logic [3:0]      charger_phase;
      logic            low_flag;
      logic            announce;
   } result_type;

endpackage

>>> hw/rtl/bgc_median.sv
// Rank-based median of the filled window entries (upper middle for even counts).
module bgc_median (
   input  bgc_pkg::win_type                window,
   input  logic [bgc_pkg::CNT_W-1:0]       count,
   output logic [bgc_pkg::PCT_W-1:0]       median
);

   logic [bgc_pkg::CNT_W-1:0] rank [bgc_pkg::WIN_LEN];
   logic [bgc_pkg::CNT_W-1:0] half;

   assign half = count >> 1;

   // ties broken by position so every filled entry gets a distinct rank
   always_comb begin
      for (int i = 0; i < bgc_pkg::WIN_LEN; i++) begin
         rank[i] = '0;
         for (int j = 0; j < bgc_pkg::WIN_LEN; j++) begin
            if ((bgc_pkg::CNT_W'(j) < count) &&
                ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i)))) begin
               rank[i] = rank[i] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      median = '0;
      for (int i = 0; i < bgc_pkg::WIN_LEN; i++) begin
         if ((bgc_pkg::CNT_W'(i) < count) && (rank[i] == half)) begin
            median = window[i];
         end
      end
   end

endmodule

>>> hw/rtl/bgc_core.sv
// Sample window, deadband, low hysteresis and held result state.
module bgc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  bgc_pkg::item_type    item,
   input  bgc_pkg::cfg_type     cfg,
   output bgc_pkg::result_type  result
);

   bgc_pkg::win_type                window_ff, window_in;
   logic [bgc_pkg::CNT_W-1:0]       fill_ff, fill_in;
   logic                            rep_none_ff;
   logic [bgc_pkg::PCT_W-1:0]       rep_ff, rep_in;
   logic                            prev_none_ff;
   logic [bgc_pkg::PCT_W-1:0]       prev_ff;
   logic [2:0]                      repeat_ff, repeat_in;
   logic                            out_valid_ff;
   logic [bgc_pkg::PCT_W-1:0]       out_pct_ff;
   logic [bgc_pkg::MV_W-1:0]        out_mv_ff, mv;
   logic                            out_chg_ff, out_full_ff, out_low_ff, announce_ff;
   logic [3:0]                      out_phase_ff;

   logic [2:0]                      dir, chg;
   logic                            supply, charging, full, gauge_ok;
   logic [bgc_pkg::PCT_W-1:0]       median;
   logic                            same, lo_hit, hi_hit, take, low, announce_in;

   assign mv       = {item.volt_high[5:0], item.volt_low};
   assign dir      = item.status_two[7:5];
   assign chg      = item.status_two[2:0];
   assign supply   = item.status_one[bgc_pkg::SUPPLY_BIT];
   assign charging = supply && ((dir == bgc_pkg::DIR_CHARGE) || (chg <= bgc_pkg::CHG_CV));
   assign full     = supply && (chg == bgc_pkg::CHG_DONE);
   assign gauge_ok = item.gauge_byte <= bgc_pkg::GAUGE_MAX;

   always_comb begin
      window_in[0] = item.gauge_byte[bgc_pkg::PCT_W-1:0];
      for (int i = 1; i < bgc_pkg::WIN_LEN; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   assign fill_in = (fill_ff < bgc_pkg::CNT_W'(bgc_pkg::WIN_LEN)) ? fill_ff + 1'b1 : fill_ff;

   bgc_median u_median (
      .window (window_in),
      .count  (fill_in),
      .median (median)
   );

   // repeat counter saturates at the settle count
   always_comb begin
      same = !prev_none_ff && (median == prev_ff);
      if (!same) begin
         repeat_in = 3'd1;
      end else if (repeat_ff < cfg.settle_count) begin
         repeat_in = repeat_ff + 1'b1;
      end else begin
         repeat_in = repeat_ff;
      end
   end

   // deadband: median under step from the report waits for settle count
   always_comb begin
      lo_hit = ({1'b0, median} + {1'b0, cfg.report_step}) <= {1'b0, rep_ff};
      hi_hit = {1'b0, median} >= ({1'b0, rep_ff} + {1'b0, cfg.report_step});
      take   = rep_none_ff || lo_hit || hi_hit || (repeat_in >= cfg.settle_count);
      rep_in = take ? median : rep_ff;
   end

   always_comb begin
      if (out_low_ff) begin
         low = {1'b0, rep_in} <= ({1'b0, cfg.low_threshold} + {1'b0, cfg.release_margin});
      end else begin
         low = rep_in <= cfg.low_threshold;
      end
      announce_in = !out_valid_ff || (low != out_low_ff) || (charging != out_chg_ff) ||
                    (full != out_full_ff) || ({1'b0, chg} != out_phase_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rep_none_ff  <= 1'b1;
         prev_none_ff <= 1'b1;
         repeat_ff    <= '0;
         out_valid_ff <= 1'b0;
         out_mv_ff    <= '0;
         out_chg_ff   <= 1'b0;
         out_full_ff  <= 1'b0;
         out_phase_ff <= bgc_pkg::PHASE_NONE;
         out_low_ff   <= 1'b0;
         announce_ff  <= 1'b0;
      end else if (fire) begin
         announce_ff <= 1'b0;
         if (item.read_ok) begin
            out_mv_ff <= mv;
            if (!gauge_ok) begin
               out_valid_ff <= 1'b0;
               out_chg_ff   <= 1'b0;
               out_full_ff  <= 1'b0;
               fill_ff      <= '0;
               rep_none_ff  <= 1'b1;
            end else begin
               fill_ff      <= fill_in;
               rep_none_ff  <= 1'b0;
               prev_none_ff <= 1'b0;
               repeat_ff    <= repeat_in;
               out_valid_ff <= 1'b1;
               out_chg_ff   <= charging;
               out_full_ff  <= full;
               out_phase_ff <= {1'b0, chg};
               out_low_ff   <= low;
               announce_ff  <= announce_in;
            end
         end
      end
   end

   // payload side: window, medians and percent need no reset
   always_ff @(posedge clock) begin
      if (fire && item.read_ok && gauge_ok) begin
         window_ff  <= window_in;
         rep_ff     <= rep_in;
         prev_ff    <= median;
         out_pct_ff <= rep_in;
      end
   end

   always_comb begin
      result.status_valid  = out_valid_ff;
      result.percent_out   = out_valid_ff ? out_pct_ff : '0;
      result.millivolts    = out_mv_ff;
      result.is_charging   = out_chg_ff;
      result.is_full       = out_full_ff;
      result.charger_phase = out_phase_ff;
      result.low_flag      = out_low_ff;
      result.announce      = announce_ff;
   end

endmodule

>>> hw/rtl/battery_gauge_conditioner.sv
// Top level of the battery gauge conditioner: stream ports, input register, CSRs.
//
// Usage:
//  - req_* carries one poll of the power-management chip per transaction;
//    req_tuser is the read-ok flag, req_tdata the five raw bytes.
//  - rsp_* returns exactly one result transaction per request: status valid
//    in rsp_tuser, percent, millivolts, charge flags, phase, low and announce
//    in rsp_tdata.
//  - csr_* writes the four tuning registers; write only while idle.
// Timing:
//  - Order: a request is held in the input register; once the result slot is
//    free or draining, the window/median/deadband logic loads the held result
//    registers in a single pass and rsp_tvalid rises with them.
//  - Throughput is one transaction per cycle while rsp_tready stays high; the
//    five-entry rank compare network in the median unit sets the critical path.
// Reset (synchronous, active high): window empties, no percent reported,
//  phase reads 4'hF (15), tuning registers return to their defaults.
// Stall: when rsp_tready is low the result holds; one further request
//  waits in the input register, then req_tready drops.
module battery_gauge_conditioner (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: status_one, status_two, volt_high, volt_low, gauge_byte
   input  logic [bgc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: read_ok
   input  logic                            req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // rsp_tdata: percent_out, millivolts, is_charging, is_full, charger_phase,
   //            low_flag, announce, zero pad
   output logic [bgc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: status_valid
   output logic                            rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_we,
   input  logic [bgc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bgc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bgc_pkg::cfg_type    cfg_ff;
   bgc_pkg::item_type   item_ff;
   bgc_pkg::result_type result;
   logic                in_valid_ff, in_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                fire;

   // process the held request once the result slot is free or draining
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.read_ok    <= req_tuser;
         item_ff.status_one <= req_tdata[7:0];
         item_ff.status_two <= req_tdata[15:8];
         item_ff.volt_high  <= req_tdata[23:16];
         item_ff.volt_low   <= req_tdata[31:24];
         item_ff.gauge_byte <= req_tdata[39:32];
      end
   end

   // tuning registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold  <= bgc_pkg::RST_LOW_THRESHOLD;
         cfg_ff.release_margin <= bgc_pkg::RST_LOW_MARGIN;
         cfg_ff.report_step    <= bgc_pkg::RST_REPORT_STEP;
         cfg_ff.settle_count   <= bgc_pkg::RST_SETTLE_COUNT;
      end else if (csr_we) begin
         unique case (csr_addr)
            bgc_pkg::CSR_LOW_THRESHOLD: cfg_ff.low_threshold  <= csr_wdata;
            bgc_pkg::CSR_LOW_MARGIN:    cfg_ff.release_margin <= csr_wdata;
            bgc_pkg::CSR_REPORT_STEP:   cfg_ff.report_step    <= csr_wdata;
            bgc_pkg::CSR_SETTLE_COUNT:  cfg_ff.settle_count   <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   bgc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result.status_valid;
   assign rsp_tdata  = {3'b000, result.announce, result.low_flag, result.charger_phase,
                        result.is_full, result.is_charging, result.millivolts,
                        result.percent_out};

endmodule

>>> hw/rtl/bgc_checker.sv
// Port-level checks for the battery gauge conditioner, bound to the top level.
module bgc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic [bgc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // after reset nothing pending and the input side is open
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // without a valid percent: percent reads zero, charge flags are clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[6:0] == 7'd0) && !rsp_tdata[21] && !rsp_tdata[22])
      else $error("invalid status carries percent or charge flags");

   // announce only comes with a valid sample, and percent stays in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[28] |-> rsp_tuser && (rsp_tdata[6:0] <= 7'd100))
      else $error("announce without valid percent");

endmodule

bind battery_gauge_conditioner bgc_checker u_checker (.*);
